FILE: design/mbd_pkg.sv
`default_nettype none

package mbd_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int ROW_W      = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_IN_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_MODE = 2'd2;

    localparam logic [1:0] CH_MODE_ONE  = 2'd0;
    localparam logic [1:0] CH_MODE_TWO  = 2'd1;
    localparam logic [1:0] CH_MODE_FOUR = 2'd2;

    localparam logic [CFG_DATA_W-1:0] HEIGHT_LIMIT = 13'd4096;

    typedef struct packed {
        logic [7:0] px_c0;
        logic [7:0] px_c1;
        logic [7:0] px_c2;
        logic [7:0] px_c3;
    } t_px_in;

    typedef struct packed {
        logic [7:0] avg_c0;
        logic [7:0] avg_c1;
        logic [7:0] avg_c2;
        logic [7:0] avg_c3;
        logic       last_pixel;
    } t_px_out;

    typedef logic [3:0][8:0] t_pair;

    typedef struct packed {
        logic  emit;
        logic  h1;
        logic  last;
        t_pair pair;
    } t_op;

endpackage

`default_nettype wire

FILE: design/mip_box_downsample_2x2.sv
// 2x2 box-filter mipmap downsampler. Source pixels enter in raster order, at
// most one transaction per clock, and each 2x2 block leaves as one pixel
// holding the per-channel floor of the block sum over four, with last_pixel
// set on the final pixel of the level. The sustained rate is one source pixel
// per cycle without stalls, set by the line store of upper-row pair sums,
// which sees one write or one read per pixel; a result passes the op queue,
// line store and output register. An odd last column or row is dropped, a
// width or height of one is replicated, and channels unused by the channel
// mode read as zero. Configuration may only be written while no transaction
// is in flight. MAX_WIDTH sets the line store depth to half the widest row.
`default_nettype none

module mip_box_downsample_2x2
    import mbd_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    input  wire t_px_in                i_pix,
    output logic                       o_stall,
    output logic                       o_valid,
    output t_px_out                    o_res,
    input  wire logic                  i_stall
);

    localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    logic          push, pop, q_full, q_nempty;
    t_op           f_op, q_op;
    logic [AW-1:0] f_slot, q_slot;

    mbd_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .i_pix      (i_pix),
        .o_stall    (o_stall),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_op       (f_op),
        .o_slot     (f_slot)
    );

    mbd_queue #(.AW(AW)) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_op     (f_op),
        .i_slot   (f_slot),
        .o_full   (q_full),
        .o_nempty (q_nempty),
        .i_pop    (pop),
        .o_op     (q_op),
        .o_slot   (q_slot)
    );

    mbd_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_nempty (q_nempty),
        .i_op       (q_op),
        .i_slot     (q_slot),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .o_res      (o_res),
        .i_stall    (i_stall)
    );

endmodule

`default_nettype wire

FILE: design/mbd_ram.sv
`default_nettype none

module mbd_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 2048
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                           i_wdata,
    input  wire logic                                       i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: design/mbd_front.sv
`default_nettype none

module mbd_front
    import mbd_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    input  wire t_px_in                i_pix,
    output logic                       o_stall,
    input  wire logic                  i_q_full,
    output logic                       o_push,
    output t_op                        o_op,
    output logic [((((MAX_WIDTH + 1) / 2) > 1) ? $clog2((MAX_WIDTH + 1) / 2) : 1)-1:0] o_slot
);

    localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int AW  = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WDW = ($clog2(MAX_WIDTH + 1) > CFG_DATA_W) ?
                         $clog2(MAX_WIDTH + 1) : CFG_DATA_W;
    localparam logic [WDW-1:0] MAX_W = WDW'(MAX_WIDTH);

    logic [CFG_DATA_W-1:0] r_in_width;
    logic [CFG_DATA_W-1:0] r_in_height;
    logic [1:0]            r_ch_mode;
    logic [CW-1:0]         r_col, n_col;
    logic [ROW_W-1:0]      r_row, n_row;
    logic [3:0][7:0]       r_held, n_held;

    logic [WDW-1:0]        cfg_w, w, wo, xe, xn, x_half;
    logic [CFG_DATA_W-1:0] h, ho, ye, yn;
    logic                  restart, w1, h1, have_pair, accept;
    logic [3:0][7:0]       px;
    t_pair                 pair;

    assign accept  = i_valid && !o_stall;
    assign o_stall = i_q_full;

    always_comb begin
        cfg_w = WDW'(r_in_width);
        if (cfg_w == '0) begin
            w = WDW'(1);
        end else if (cfg_w > MAX_W) begin
            w = MAX_W;
        end else begin
            w = cfg_w;
        end
        if (r_in_height == '0) begin
            h = CFG_DATA_W'(1);
        end else if (r_in_height > HEIGHT_LIMIT) begin
            h = HEIGHT_LIMIT;
        end else begin
            h = r_in_height;
        end
        wo = ((w >> 1) == '0) ? WDW'(1) : (w >> 1);
        ho = ((h >> 1) == '0) ? CFG_DATA_W'(1) : (h >> 1);
        w1 = (w == WDW'(1));
        h1 = (h == CFG_DATA_W'(1));

        restart = (WDW'(r_col) >= w) || (CFG_DATA_W'(r_row) >= h);
        xe = restart ? '0 : WDW'(r_col);
        ye = restart ? '0 : CFG_DATA_W'(r_row);
        x_half = xe >> 1;

        px[0] = i_pix.px_c0;
        px[1] = (r_ch_mode != CH_MODE_ONE) ? i_pix.px_c1 : 8'd0;
        px[2] = (r_ch_mode != CH_MODE_ONE && r_ch_mode != CH_MODE_TWO) ? i_pix.px_c2 : 8'd0;
        px[3] = (r_ch_mode != CH_MODE_ONE && r_ch_mode != CH_MODE_TWO) ? i_pix.px_c3 : 8'd0;

        n_held    = r_held;
        have_pair = 1'b0;
        for (int c = 0; c < 4; c++) begin
            pair[c] = w1 ? {px[c], 1'b0} : ({1'b0, r_held[c]} + {1'b0, px[c]});
        end
        if (w1 || xe[0]) begin
            have_pair = 1'b1;
        end else if ((xe + WDW'(1)) < w) begin
            n_held = px;
        end

        xn = xe + WDW'(1);
        yn = ye;
        if (xn >= w) begin
            xn = '0;
            yn = ye + CFG_DATA_W'(1);
            if (yn >= h) begin
                yn = '0;
            end
        end
        n_col = xn[CW-1:0];
        n_row = yn[ROW_W-1:0];

        o_op.emit = h1 || ye[0];
        o_op.h1   = h1;
        o_op.last = (x_half == (wo - WDW'(1))) && ((ye >> 1) == (ho - CFG_DATA_W'(1)));
        o_op.pair = pair;
        o_slot    = x_half[AW-1:0];
        o_push    = accept && have_pair &&
                    (h1 || ye[0] || ((ye + CFG_DATA_W'(1)) < h));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_width  <= CFG_DATA_W'(2);
            r_in_height <= CFG_DATA_W'(2);
            r_ch_mode   <= CH_MODE_FOUR;
            r_col       <= '0;
            r_row       <= '0;
            r_held      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_IN_WIDTH:     r_in_width  <= i_cfg_data;
                    CFG_IN_HEIGHT:    r_in_height <= i_cfg_data;
                    CFG_CHANNEL_MODE: r_ch_mode   <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_col  <= n_col;
                r_row  <= n_row;
                r_held <= n_held;
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/mbd_queue.sv
`default_nettype none

module mbd_queue
    import mbd_pkg::*;
#(
    parameter int AW = 11
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire t_op           i_op,
    input  wire logic [AW-1:0] i_slot,
    output logic               o_full,
    output logic               o_nempty,
    input  wire logic          i_pop,
    output t_op                o_op,
    output logic [AW-1:0]      o_slot
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    t_op             r_op   [DEPTH];
    logic [AW-1:0]   r_slot [DEPTH];
    logic [PW-1:0]   r_wptr, r_rptr;
    logic [PW:0]     r_count, n_count;

    assign o_full   = (r_count == (PW + 1)'(DEPTH));
    assign o_nempty = (r_count != '0);
    assign o_op     = r_op[r_rptr];
    assign o_slot   = r_slot[r_rptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + (PW + 1)'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - (PW + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_op[r_wptr]   <= i_op;
            r_slot[r_wptr] <= i_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + PW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + PW'(1);
            end
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

FILE: design/mbd_back.sv
`default_nettype none

module mbd_back
    import mbd_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_q_nempty,
    input  wire t_op     i_op,
    input  wire logic [((((MAX_WIDTH + 1) / 2) > 1) ? $clog2((MAX_WIDTH + 1) / 2) : 1)-1:0] i_slot,
    output logic         o_pop,
    output logic         o_valid,
    output t_px_out      o_res,
    input  wire logic    i_stall
);

    localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;

    logic    r_b_valid, r_o_valid;
    t_op     r_b_op;
    t_px_out r_res, n_res;
    t_pair   rdata, upper;
    logic    out_free, ram_we, ram_re;

    assign out_free = !r_o_valid || !i_stall;
    assign o_pop    = i_q_nempty && (!r_b_valid || out_free);
    assign ram_we   = o_pop && !i_op.emit;
    assign ram_re   = o_pop && i_op.emit;

    mbd_ram #(
        .WIDTH ($bits(t_pair)),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_slot),
        .i_wdata (i_op.pair),
        .i_re    (ram_re),
        .i_raddr (i_slot),
        .o_rdata (rdata)
    );

    always_comb begin
        logic [9:0] s0, s1, s2, s3;
        upper = r_b_op.h1 ? r_b_op.pair : rdata;
        s0 = {1'b0, upper[0]} + {1'b0, r_b_op.pair[0]};
        s1 = {1'b0, upper[1]} + {1'b0, r_b_op.pair[1]};
        s2 = {1'b0, upper[2]} + {1'b0, r_b_op.pair[2]};
        s3 = {1'b0, upper[3]} + {1'b0, r_b_op.pair[3]};
        n_res.avg_c0     = s0[9:2];
        n_res.avg_c1     = s1[9:2];
        n_res.avg_c2     = s2[9:2];
        n_res.avg_c3     = s3[9:2];
        n_res.last_pixel = r_b_op.last;
    end

    always_ff @(posedge i_clk) begin
        if (ram_re) begin
            r_b_op <= i_op;
        end
        if (out_free && r_b_valid) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (ram_re) begin
                r_b_valid <= 1'b1;
            end else if (out_free) begin
                r_b_valid <= 1'b0;
            end
            if (out_free) begin
                r_o_valid <= r_b_valid;
            end
        end
    end

    assign o_valid = r_o_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

FILE: design/mbd_checker.sv
`default_nettype none

module mbd_checker
    import mbd_pkg::*;
(
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    i_valid,
    input wire logic    o_stall,
    input wire logic    o_valid,
    input wire t_px_out o_res,
    input wire logic    i_stall
);

    logic [31:0] r_open;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else begin
            r_open <= r_open + 32'(i_valid && !o_stall) - 32'(o_valid && !i_stall);
        end
    end

    // A result can only follow an input transaction that has not been answered.
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_open != '0))
        else $error("result without an open input transaction");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_res))
        else $error("stalled result changed");

endmodule

bind mip_box_downsample_2x2 mbd_checker u_mbd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .o_res   (o_res),
    .i_stall (i_stall)
);

`default_nettype wire

FILE: test/tb_mip_box_downsample_2x2.sv
module tb_mip_box_downsample_2x2;
    import mbd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_PERIOD  = 8;
    localparam int          MAX_W       = 4096;
    localparam int          LINE_DEPTH  = (MAX_W + 1) / 2;
    localparam int          SETTLE      = 10;
    localparam int          RX_HOLD     = 400;
    localparam int          RAND_PIXELS = 550;
    localparam int          EDGE_PIXELS = 128;
    localparam int unsigned CYCLE_LIMIT = 4000000;

    localparam logic [1:0]           CH_MODE_SPARE  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

    typedef enum int {FILL_RAND, FILL_ZERO, FILL_FULL, FILL_CHECKER} t_fill;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid    = 1'b0;
    t_px_in                i_pix      = '0;
    logic                  i_stall    = 1'b0;
    logic                  o_stall;
    logic                  o_valid;
    t_px_out               o_res;

    mip_box_downsample_2x2 #(
        .MAX_WIDTH(MAX_W)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_valid   (i_valid),
        .i_pix     (i_pix),
        .o_stall   (o_stall),
        .o_valid   (o_valid),
        .o_res     (o_res),
        .i_stall   (i_stall)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Shadow of the downsampler state.
    logic [CFG_DATA_W-1:0] cfg_w    = 13'd2;
    logic [CFG_DATA_W-1:0] cfg_h    = 13'd2;
    logic [1:0]            cfg_mode = CH_MODE_FOUR;
    logic [3:0][8:0]       line_sums [LINE_DEPTH];
    logic [7:0]            held_px [4];
    int unsigned           col_n = 0;
    int unsigned           row_n = 0;

    t_px_in      pix_q[$];
    t_px_out     avg_expect_q[$];
    bit          pix_taken   = 1'b0;
    bit          rx_hold_req = 1'b0;
    int unsigned src_gap     = 0;
    int unsigned src_calm    = 0;
    int unsigned rx_calm     = 0;
    int unsigned rx_left     = 0;
    int unsigned rx_hold_left = 0;
    bit          rx_level    = 1'b0;
    int unsigned cyc_cnt     = 0;
    int unsigned err_cnt     = 0;
    int unsigned px_sent     = 0;
    int unsigned res_checked = 0;
    int unsigned held_off    = 0;
    int unsigned cfg_phases  = 0;

    function automatic int unsigned eff_dim(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int unsigned idle_len(inout int unsigned calm);
        int unsigned r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r == 0) begin
            calm = $urandom_range(100, 300);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    task automatic note_error(input string msg);
        err_cnt++;
        if (err_cnt <= 100) $display("ERROR at cycle %0d: %s", cyc_cnt, msg);
    endtask

    task automatic predict_avg(input t_px_in p);
        int unsigned w, h, nch, wo, ho, x, y, slot, up;
        logic [7:0] px [4];
        logic [8:0] pr [4];
        logic [7:0] avg [4];
        bit have_pair;
        t_px_out r;
        w   = eff_dim(cfg_w, MAX_W);
        h   = eff_dim(cfg_h, HEIGHT_LIMIT);
        nch = (cfg_mode == CH_MODE_ONE) ? 1 : ((cfg_mode == CH_MODE_TWO) ? 2 : 4);
        wo  = (w / 2 != 0) ? w / 2 : 1;
        ho  = (h / 2 != 0) ? h / 2 : 1;
        if (col_n >= w || row_n >= h) begin
            col_n = 0;
            row_n = 0;
        end
        x = col_n;
        y = row_n;
        px[0] = p.px_c0;
        px[1] = p.px_c1;
        px[2] = p.px_c2;
        px[3] = p.px_c3;
        for (int c = 0; c < 4; c++) begin
            if (c >= nch) px[c] = 8'd0;
            pr[c] = '0;
        end
        have_pair = 1'b0;
        if (w == 1) begin
            for (int c = 0; c < 4; c++) pr[c] = {px[c], 1'b0};
            have_pair = 1'b1;
        end else if (x % 2 != 0) begin
            for (int c = 0; c < 4; c++) pr[c] = 9'(held_px[c]) + 9'(px[c]);
            have_pair = 1'b1;
        end else if (x + 1 < w) begin
            for (int c = 0; c < 4; c++) held_px[c] = px[c];
        end
        if (have_pair) begin
            slot = (x >> 1) % LINE_DEPTH;
            if (h == 1 || y % 2 != 0) begin
                for (int c = 0; c < 4; c++) begin
                    up = (h == 1) ? pr[c] : line_sums[slot][c];
                    avg[c] = 8'((up + pr[c]) >> 2);
                end
                r.avg_c0     = avg[0];
                r.avg_c1     = avg[1];
                r.avg_c2     = avg[2];
                r.avg_c3     = avg[3];
                r.last_pixel = ((x >> 1) == wo - 1) && ((y >> 1) == ho - 1);
                avg_expect_q.push_back(r);
            end else if (y + 1 < h) begin
                for (int c = 0; c < 4; c++) line_sums[slot][c] = pr[c];
            end
        end
        x++;
        if (x >= w) begin
            x = 0;
            y++;
            if (y >= h) y = 0;
        end
        col_n = x;
        row_n = y;
    endtask

    // Acceptance side of the input channel, register shadow and run limit.
    always @(posedge i_clk) begin
        cyc_cnt++;
        if (cyc_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cyc_cnt, avg_expect_q.size());
            $display("TB_ERROR");
            $finish;
        end
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_IN_WIDTH:     cfg_w    = i_cfg_data;
                    CFG_IN_HEIGHT:    cfg_h    = i_cfg_data;
                    CFG_CHANNEL_MODE: cfg_mode = i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) begin
                predict_avg(i_pix);
                void'(pix_q.pop_front());
                pix_taken = 1'b1;
                px_sent++;
            end
            if (i_valid && o_stall) held_off++;
        end
    end

    // Pixel driver.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !pix_taken) begin
            // Stalled transaction stays on the bus unchanged.
        end else begin
            pix_taken = 1'b0;
            if (src_gap > 0) begin
                src_gap--;
                i_valid <= 1'b0;
            end else if (pix_q.size() != 0) begin
                i_valid <= 1'b1;
                i_pix   <= pix_q[0];
                src_gap = idle_len(src_calm);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result receiver stall pattern.
    always @(negedge i_clk) begin
        int unsigned n;
        if (rx_hold_req) begin
            rx_hold_left = RX_HOLD;
            rx_hold_req  = 1'b0;
        end
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            i_stall <= 1'b1;
        end else if (rx_left != 0) begin
            rx_left--;
            i_stall <= rx_level;
        end else if (rx_level) begin
            rx_level = 1'b0;
            rx_left  = $urandom_range(0, 7);
            i_stall <= 1'b0;
        end else begin
            n = idle_len(rx_calm);
            if (n > 0) begin
                rx_level = 1'b1;
                rx_left  = n - 1;
                i_stall <= 1'b1;
            end else begin
                rx_left = $urandom_range(0, 7);
                i_stall <= 1'b0;
            end
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        t_px_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (avg_expect_q.size() == 0) begin
                note_error($sformatf("unexpected result %h %h %h %h last %b",
                           o_res.avg_c0, o_res.avg_c1, o_res.avg_c2, o_res.avg_c3,
                           o_res.last_pixel));
            end else begin
                want = avg_expect_q.pop_front();
                if (o_res.avg_c0 !== want.avg_c0 || o_res.avg_c1 !== want.avg_c1 ||
                    o_res.avg_c2 !== want.avg_c2 || o_res.avg_c3 !== want.avg_c3 ||
                    o_res.last_pixel !== want.last_pixel) begin
                    note_error($sformatf(
                        "result %0d got %h %h %h %h last %b, want %h %h %h %h last %b",
                        res_checked, o_res.avg_c0, o_res.avg_c1, o_res.avg_c2,
                        o_res.avg_c3, o_res.last_pixel, want.avg_c0, want.avg_c1,
                        want.avg_c2, want.avg_c3, want.last_pixel));
                end
                res_checked++;
            end
        end
    end

    task automatic push_pixels(input int unsigned n, input t_fill fill);
        t_px_in p;
        for (int unsigned i = 0; i < n; i++) begin
            case (fill)
                FILL_ZERO:    p = '0;
                FILL_FULL:    p = '1;
                FILL_CHECKER: p = (i % 2 != 0) ? {4{8'hAA}} : {4{8'h55}};
                default:      p = t_px_in'($urandom);
            endcase
            pix_q.push_back(p);
        end
    endtask

    task automatic drain();
        while (pix_q.size() != 0 || avg_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic write_mode(input logic [1:0] mode);
        write_cfg(CFG_CHANNEL_MODE, {11'($urandom), mode});
    endtask

    task automatic set_image(input int unsigned w, input int unsigned h,
                             input logic [1:0] mode);
        write_cfg(CFG_IN_WIDTH, 13'(w));
        write_cfg(CFG_IN_HEIGHT, 13'(h));
        write_mode(mode);
        cfg_phases++;
    endtask

    // Pixel count of one whole image at the current shadow settings.
    function automatic int unsigned image_pixels();
        return eff_dim(cfg_w, MAX_W) * eff_dim(cfg_h, HEIGHT_LIMIT);
    endfunction

    initial begin
        int unsigned w, h, reps, rand_px;
        logic [1:0] mode;
        bit first;
        foreach (line_sums[i]) line_sums[i] = '0;
        foreach (held_px[i]) held_px[i] = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed: reset settings with black and white blocks, then tiny and odd image sizes.
        push_pixels(4, FILL_ZERO);
        push_pixels(4, FILL_FULL);
        drain();
        set_image(1, 2, CH_MODE_FOUR);
        push_pixels(2, FILL_CHECKER);
        drain();
        set_image(2, 1, CH_MODE_TWO);
        push_pixels(2, FILL_RAND);
        drain();
        set_image(3, 3, CH_MODE_ONE);
        push_pixels(9, FILL_RAND);
        drain();
        write_cfg(CFG_IDX_UNUSED, 13'($urandom));

        // Directed: settings changed in the middle of an image.
        set_image(4, 4, CH_MODE_FOUR);
        push_pixels(6, FILL_RAND);
        drain();
        write_mode(CH_MODE_ONE);
        push_pixels(2, FILL_RAND);
        drain();
        write_cfg(CFG_IN_HEIGHT, 13'd1);
        push_pixels(4, FILL_RAND);
        drain();

        // Register extremes, including out-of-range codes. The widest and
        // tallest settings run only the leading part of the image.
        set_image(0, 0, CH_MODE_SPARE);
        push_pixels(image_pixels(), FILL_RAND);
        drain();
        set_image(MAX_W, 2, CH_MODE_TWO);
        push_pixels(EDGE_PIXELS, FILL_RAND);
        drain();
        set_image(8191, 1, CH_MODE_SPARE);
        push_pixels(EDGE_PIXELS, FILL_RAND);
        drain();
        set_image(1, 4096, CH_MODE_ONE);
        push_pixels(EDGE_PIXELS, FILL_RAND);
        drain();
        set_image(1, 8191, CH_MODE_FOUR);
        push_pixels(EDGE_PIXELS, FILL_RAND);
        drain();

        // Random images, mostly small.
        rand_px = 0;
        first   = 1'b1;
        while (rand_px < RAND_PIXELS) begin
            if (first) begin
                w = 16;
                h = 8;
            end else begin
                case ($urandom_range(0, 19))
                    0: begin
                        w = $urandom_range(0, 1) ? 0 : $urandom_range(33, 64);
                        h = $urandom_range(0, 4);
                    end
                    1, 2, 3, 4: begin
                        w = $urandom_range(9, 32);
                        h = $urandom_range(1, 6);
                    end
                    default: begin
                        w = $urandom_range(1, 8);
                        h = $urandom_range(1, 16);
                    end
                endcase
            end
            mode = 2'($urandom_range(CH_MODE_ONE, CH_MODE_SPARE));
            if ($urandom_range(0, 9) == 0) write_cfg(CFG_IDX_UNUSED, 13'($urandom));
            set_image(w, h, mode);
            reps = $urandom_range(1, 3);
            if (first) rx_hold_req = 1'b1;
            for (int unsigned i = 0; i < reps; i++) begin
                push_pixels(image_pixels(), ($urandom_range(0, 15) == 0) ?
                            FILL_CHECKER : FILL_RAND);
                rand_px += image_pixels();
            end
            drain();
            first = 1'b0;
        end

        drain();
        $display("covered %0d source pixels over %0d settings: whole images up to 64",
                 px_sent, cfg_phases);
        $display("wide, leading rows at the 4096 limits, all modes, %0d results checked",
                 res_checked);
        $display("input held off for %0d cycles", held_off);
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/mbd_pkg.sv
design/mbd_ram.sv
design/mbd_front.sv
design/mbd_queue.sv
design/mbd_back.sv
design/mip_box_downsample_2x2.sv
design/mbd_checker.sv
test/tb_mip_box_downsample_2x2.sv
